// File: hdl/lpkv_pkg.sv
package lpkv_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int CMD_W  = 2;
    localparam int KEY_W  = 31;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;

    localparam int IN_TDATA_W  = ((CMD_W + KEY_W + VAL_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((STAT_W + VAL_W + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_GET    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUT    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

    localparam logic [1:0] SLOT_EMPTY   = 2'd0;
    localparam logic [1:0] SLOT_USED    = 2'd1;
    localparam logic [1:0] SLOT_DELETED = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
        logic [SLOT_W-1:0] home;
    } job_t;

    typedef struct packed {
        logic [1:0]       state;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } slot_t;

    typedef struct packed {
        logic init_done;
    } eng_stat_t;

endpackage

// File: hdl/lpkv_front.sv
module lpkv_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [lpkv_pkg::IN_TDATA_W-1:0]   s_tdata,   // cmd, key, value
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  lpkv_pkg::eng_stat_t               eng_stat,
    output lpkv_pkg::job_t                    push_job,
    output logic                              push_valid,
    input  logic                              push_ready
);
    import lpkv_pkg::*;

    logic busy_reg, busy_next;
    job_t job_reg, job_next;
    logic accept;

    assign s_tready   = !busy_reg && eng_stat.init_done;
    assign accept     = s_tvalid && s_tready;
    assign push_valid = busy_reg;
    assign push_job   = job_reg;

    // The table depth is a power of two, so the home slot is the low bits of the key.
    always_comb begin
        busy_next = busy_reg;
        job_next  = job_reg;
        if (accept) begin
            busy_next      = 1'b1;
            job_next.cmd   = s_tdata[CMD_W-1:0];
            job_next.key   = s_tdata[CMD_W+KEY_W-1:CMD_W];
            job_next.value = s_tdata[CMD_W+KEY_W+VAL_W-1:CMD_W+KEY_W];
            job_next.home  = s_tdata[CMD_W+SLOT_W-1:CMD_W];
        end else if (push_valid && push_ready) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        job_reg <= job_next;
    end

endmodule

// File: hdl/lpkv_queue.sv
module lpkv_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  lpkv_pkg::job_t push_job,
    input  logic           push_valid,
    output logic           push_ready,
    output lpkv_pkg::job_t pop_job,
    output logic           pop_valid,
    input  logic           pop_ready
);
    import lpkv_pkg::*;

    job_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: hdl/lpkv_engine.sv
module lpkv_engine (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  lpkv_pkg::job_t                   pop_job,
    input  logic                             pop_valid,
    output logic                             pop_ready,
    output lpkv_pkg::eng_stat_t              eng_stat,
    output logic [lpkv_pkg::OUT_TDATA_W-1:0] m_tdata,   // status, found_value
    output logic                             m_tvalid,
    input  logic                             m_tready
);
    import lpkv_pkg::*;

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_CLR  = 3'd4;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_DEPTH - 1);
    localparam logic [CNT_W-1:0]  LAST_CNT  = CNT_W'(TABLE_DEPTH - 1);

    slot_t             mem [TABLE_DEPTH];
    slot_t             rd_reg;
    logic              mem_we, mem_re;
    logic [SLOT_W-1:0] mem_addr;
    slot_t             mem_wdata;

    logic [2:0]        state_reg, state_next;
    logic              init_done_reg, init_done_next;
    job_t              job_reg, job_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [SLOT_W-1:0] free_reg, free_next;
    logic              free_vld_reg, free_vld_next;

    logic                   out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;
    logic                   out_free, out_load;
    logic [STAT_W-1:0]      res_status;
    logic [VAL_W-1:0]       res_value;

    logic              is_empty, is_hit, is_free, at_last, probe_done;
    logic              free_now_vld;
    logic [SLOT_W-1:0] free_now, idx_inc;

    assign eng_stat.init_done = init_done_reg;
    assign pop_ready          = (state_reg == S_IDLE);
    assign m_tvalid           = out_valid_reg;
    assign m_tdata            = out_data_reg;
    assign out_free           = !out_valid_reg || m_tready;

    assign is_empty     = (rd_reg.state == SLOT_EMPTY);
    assign is_hit       = (rd_reg.state == SLOT_USED) && (rd_reg.key == job_reg.key);
    assign is_free      = (rd_reg.state != SLOT_USED);
    assign at_last      = (n_reg == LAST_CNT);
    assign probe_done   = is_empty || is_hit || at_last;
    assign free_now_vld = free_vld_reg || is_free;
    assign free_now     = free_vld_reg ? free_reg : idx_reg;
    assign idx_inc      = (idx_reg == LAST_SLOT) ? '0 : idx_reg + 1'b1;

    always_comb begin
        state_next     = state_reg;
        init_done_next = init_done_reg;
        job_next       = job_reg;
        idx_next       = idx_reg;
        n_next         = n_reg;
        free_next      = free_reg;
        free_vld_next  = free_vld_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_addr       = idx_reg;
        mem_wdata      = '{state: SLOT_EMPTY, key: job_reg.key, value: job_reg.value};
        out_load       = 1'b0;
        res_status     = STAT_OK;
        res_value      = '0;
        unique case (state_reg)
            S_INIT: begin
                mem_we = 1'b1;
                if (idx_reg == LAST_SLOT) begin
                    state_next     = S_IDLE;
                    init_done_next = 1'b1;
                    idx_next       = '0;
                end else begin
                    idx_next = idx_inc;
                end
            end
            S_IDLE: begin
                if (pop_valid) begin
                    job_next      = pop_job;
                    n_next        = '0;
                    free_vld_next = 1'b0;
                    if (pop_job.cmd == CMD_CLEAR) begin
                        idx_next   = '0;
                        state_next = S_CLR;
                    end else begin
                        idx_next   = pop_job.home;
                        state_next = S_RD;
                    end
                end
            end
            S_RD: begin
                mem_re     = 1'b1;
                state_next = S_CHK;
            end
            S_CHK: begin
                if (!probe_done) begin
                    free_next     = free_now;
                    free_vld_next = free_now_vld;
                    n_next        = n_reg + 1'b1;
                    idx_next      = idx_inc;
                    state_next    = S_RD;
                end else if (out_free) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                    unique case (job_reg.cmd)
                        CMD_GET: begin
                            if (is_hit) begin
                                res_value = rd_reg.value;
                            end else begin
                                res_status = STAT_MISS;
                            end
                        end
                        CMD_PUT: begin
                            mem_wdata.state = SLOT_USED;
                            if (is_hit) begin
                                mem_we = 1'b1;
                            end else if (free_now_vld) begin
                                mem_we   = 1'b1;
                                mem_addr = free_now;
                            end else begin
                                res_status = STAT_FULL;
                            end
                        end
                        CMD_DELETE: begin
                            mem_wdata.state = SLOT_DELETED;
                            if (is_hit) begin
                                mem_we = 1'b1;
                            end else begin
                                res_status = STAT_MISS;
                            end
                        end
                        default: begin
                            res_status = STAT_OK;
                        end
                    endcase
                end
            end
            S_CLR: begin
                mem_we = 1'b1;
                if (idx_reg != LAST_SLOT) begin
                    idx_next = idx_inc;
                end else if (out_free) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
            out_data_next  = OUT_TDATA_W'({res_value, res_status});
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_INIT;
            init_done_reg <= 1'b0;
            idx_reg       <= '0;
            n_reg         <= '0;
            free_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            init_done_reg <= init_done_next;
            idx_reg       <= idx_next;
            n_reg         <= n_next;
            free_vld_reg  <= free_vld_next;
            out_valid_reg <= out_valid_next;
        end
        job_reg      <= job_next;
        free_reg     <= free_next;
        out_data_reg <= out_data_next;
    end

`ifndef ASSERT_OFF
    a_port_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_we && mem_re))
        else $error("slot memory written and read in the same cycle");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!out_valid_reg || m_tready))
        else $error("result word loaded over an untaken word");

    a_probe_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CHK) |-> (n_reg <= LAST_CNT))
        else $error("probe ran past the table depth");

    a_pop_after_init: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop_valid && pop_ready) |-> init_done_reg)
        else $error("job taken before the clearing pass finished");
`endif

endmodule

// File: hdl/linear_probe_key_value_table.sv
// Flow: the front register holds an accepted word, the two-entry queue passes it on and the
// probe engine pops it while idle; a get, put or delete reads and checks each slot it visits,
// a clear writes every slot, and the result loads once the output register is free. The
// engine, with one slot memory port, takes a new word only after it loads the last result.
// Reset: aresetn is synchronous, active low; afterwards a clearing pass writes every slot
// empty, one per cycle, with s_tready held low.
module linear_probe_key_value_table (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [lpkv_pkg::IN_TDATA_W-1:0]  s_tdata,   // cmd, key, value
    input  logic                             s_tvalid,
    output logic                             s_tready,
    output logic [lpkv_pkg::OUT_TDATA_W-1:0] m_tdata,   // status, found_value
    output logic                             m_tvalid,
    input  logic                             m_tready
);
    import lpkv_pkg::*;

    eng_stat_t eng_stat;
    job_t      push_job, pop_job;
    logic      push_valid, push_ready;
    logic      pop_valid, pop_ready;

    lpkv_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tdata    (s_tdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .eng_stat   (eng_stat),
        .push_job   (push_job),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    lpkv_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_job   (push_job),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_job    (pop_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    lpkv_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_job   (pop_job),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .eng_stat  (eng_stat),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready)
    );

endmodule
